// ----- rtl/core/hwcfl_pkg.sv -----
// Shared types and constants for the wave speed and CFL block.
package hwcfl_pkg;

  localparam int DATA_W     = 32;
  localparam int GAMMA_W    = 16;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int SHIFT_Q    = 18;              // 2*16 - 14 fraction bits
  localparam int NUM_W      = GAMMA_W + DATA_W;
  localparam int DIV_W      = NUM_W + SHIFT_Q; // dividend width
  localparam int DIV_STEPS  = DIV_W;           // one quotient bit per step
  localparam int SQRT_STEPS = 32;              // one root bit per step
  localparam int CNT_W      = 7;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Z = 2'd3;

  // Axis codes.
  localparam logic [DIR_W-1:0] DIR_X = 2'd0;
  localparam logic [DIR_W-1:0] DIR_Y = 2'd1;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd27307;
  localparam logic [DATA_W-1:0]  INV_RESET   = 32'd65536;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_SQI   = 8'b0000_1000,
    S_SQRT  = 8'b0001_0000,
    S_SPEED = 8'b0010_0000,
    S_CMUL  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic load;
    logic side;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic sqrt_last;
    logic speed;
    logic cfl_mul;
    logic finish;
  } cmd_t;

endpackage

// ----- rtl/core/hwcfl_ctrl.sv -----
// Sequencer for the wave speed block: handshakes, step counts, datapath commands.
module hwcfl_ctrl import hwcfl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             side_r, side_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Decode state into commands and next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    side_nxt  = side_r;
    cmd       = '0;
    cmd.side  = side_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          side_nxt  = 1'b0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_SQI;
        end
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          cmd.sqrt_last = 1'b1;
          if (!side_r) begin
            side_nxt  = 1'b1;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_SPEED;
          end
        end
      end
      S_SPEED: begin
        cmd.speed = 1'b1;
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        cmd.cfl_mul = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on finish, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register not one-hot");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_MUL && !side_r))
    else $error("accepted item did not start the first side");
  a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a pending item");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(DIV_STEPS)))
    else $error("division step count overran");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finish did not raise output valid");
`endif

endmodule

// ----- rtl/core/hwcfl_dp.sv -----
// Datapath: operand registers, bit-serial divider and square root, speeds, CFL.
module hwcfl_dp import hwcfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  logic [GAMMA_W-1:0]   gamma,
  input  logic [DATA_W-1:0]    inv_x,
  input  logic [DATA_W-1:0]    inv_y,
  input  logic [DATA_W-1:0]    inv_z,
  input  logic [DATA_W-1:0]    in_density_left,
  input  logic [DATA_W-1:0]    in_density_right,
  input  logic signed [DATA_W-1:0] in_velocity_left,
  input  logic signed [DATA_W-1:0] in_velocity_right,
  input  logic [DATA_W-1:0]    in_pressure_left,
  input  logic [DATA_W-1:0]    in_pressure_right,
  input  logic [DIR_W-1:0]     in_direction,
  input  logic                 in_restart_max,
  output logic [DATA_W-1:0]    out_wave_speed_right,
  output logic [DATA_W-1:0]    out_wave_speed_left,
  output logic [DATA_W-1:0]    out_local_cfl,
  output logic [DATA_W-1:0]    out_running_cfl,
  output logic                 out_saturated
);

  logic [DATA_W-1:0]        rho_l_r, rho_r_r, p_l_r, p_r_r, inv_r;
  logic signed [DATA_W-1:0] u_l_r, u_r_r;
  logic                     restart_r, sat_r;
  logic [DIV_W-1:0]         dvd_r;
  logic [DATA_W-1:0]        rem_r;
  logic [63:0]              rad_r;
  logic [DATA_W-1:0]        root_r, cs_l_r, cs_r_r;
  logic [DATA_W:0]          srem_r;
  logic [DATA_W-1:0]        vr_r, vl_r;
  logic [2*DATA_W-1:0]      prod_r;
  logic [DATA_W-1:0]        max_r;
  logic [DATA_W-1:0]        ows_r_r, ows_l_r, ocfl_r;
  logic                     osat_r;

  logic [DATA_W-1:0] rho_side, p_side, inv_sel, vmax, cfl, max_base;
  logic [DATA_W:0]   rem_sh;
  logic              div_ge, sqrt_ge, cfl_sat;
  logic [DATA_W+2:0] srem_sh, trial;
  logic [DATA_W-1:0] root_nxt;
  logic signed [DATA_W+2:0] a_p, b_p, a_m, b_m, m_p, m_m, ul, ur, csl, csr;
  logic [DATA_W-1:0] vr_c, vl_c;
  logic              vr_sat, vl_sat;

  // Select side operands and axis
  assign rho_side = cmd.side ? rho_r_r : rho_l_r;
  assign p_side   = cmd.side ? p_r_r : p_l_r;
  always_comb begin
    case (in_direction)
      DIR_X:   inv_sel = inv_x;
      DIR_Y:   inv_sel = inv_y;
      default: inv_sel = inv_z;
    endcase
  end

  // One restoring division step
  assign rem_sh = {rem_r, dvd_r[DIV_W-1]};
  assign div_ge = rem_sh >= {1'b0, rho_side};

  // One square root digit step
  assign srem_sh  = {srem_r, rad_r[63:62]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign sqrt_ge  = srem_sh >= trial;
  assign root_nxt = {root_r[DATA_W-2:0], sqrt_ge};

  // Signed sums cs +/- u and their clipped maxima
  always_comb begin
    csl = $signed({3'b000, cs_l_r});
    csr = $signed({3'b000, cs_r_r});
    ul  = DATA_W'(0) + 35'(u_l_r);
    ur  = DATA_W'(0) + 35'(u_r_r);
    a_p = csl + ul;
    b_p = csr + ur;
    a_m = csl - ul;
    b_m = csr - ur;
    m_p = (a_p > b_p) ? a_p : b_p;
    m_m = (a_m > b_m) ? a_m : b_m;
    vr_sat = 1'b0;
    vl_sat = 1'b0;
    if (m_p[DATA_W+2]) begin
      vr_c = '0;
    end else if (m_p[DATA_W+1:DATA_W] != 2'b00) begin
      vr_c   = '1;
      vr_sat = 1'b1;
    end else begin
      vr_c = m_p[DATA_W-1:0];
    end
    if (m_m[DATA_W+2]) begin
      vl_c = '0;
    end else if (m_m[DATA_W+1:DATA_W] != 2'b00) begin
      vl_c   = '1;
      vl_sat = 1'b1;
    end else begin
      vl_c = m_m[DATA_W-1:0];
    end
  end

  assign vmax     = (vr_r > vl_r) ? vr_r : vl_r;
  assign cfl_sat  = prod_r[2*DATA_W-1:DATA_W+16] != '0;
  assign cfl      = cfl_sat ? '1 : prod_r[DATA_W+15:16];
  assign max_base = restart_r ? '0 : max_r;

  // Operand and work registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rho_l_r   <= (in_density_left == '0) ? DATA_W'(1) : in_density_left;
      rho_r_r   <= (in_density_right == '0) ? DATA_W'(1) : in_density_right;
      u_l_r     <= in_velocity_left;
      u_r_r     <= in_velocity_right;
      p_l_r     <= in_pressure_left;
      p_r_r     <= in_pressure_right;
      inv_r     <= inv_sel;
      restart_r <= in_restart_max;
      sat_r     <= 1'b0;
    end
    if (cmd.div_init) begin
      dvd_r <= {NUM_W'(gamma) * NUM_W'(p_side), SHIFT_Q'(0)};
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[DIV_W-2:0], div_ge};
      rem_r <= div_ge ? DATA_W'(rem_sh - {1'b0, rho_side}) : rem_sh[DATA_W-1:0];
    end
    if (cmd.sqrt_init) begin
      // Clip squared speed that overflows 64 bits
      if (dvd_r[DIV_W-1:64] != '0) begin
        rad_r <= '1;
        sat_r <= 1'b1;
      end else begin
        rad_r <= dvd_r[63:0];
      end
      root_r <= '0;
      srem_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[61:0], 2'b00};
      root_r <= root_nxt;
      srem_r <= sqrt_ge ? DATA_W'(0) + 33'(srem_sh - trial) : srem_sh[DATA_W:0];
      if (cmd.sqrt_last) begin
        if (cmd.side) begin
          cs_r_r <= root_nxt;
        end else begin
          cs_l_r <= root_nxt;
        end
      end
    end
    if (cmd.speed) begin
      vr_r <= vr_c;
      vl_r <= vl_c;
      if (vr_sat || vl_sat) begin
        sat_r <= 1'b1;
      end
    end
    if (cmd.cfl_mul) begin
      prod_r <= vmax * inv_r;
    end
    if (cmd.finish) begin
      ows_r_r <= vr_r;
      ows_l_r <= vl_r;
      ocfl_r  <= cfl;
      osat_r  <= sat_r || cfl_sat;
    end
  end

  // Running maximum of the local CFL
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
    end else if (cmd.finish) begin
      max_r <= (cfl > max_base) ? cfl : max_base;
    end
  end

  assign out_wave_speed_right = ows_r_r;
  assign out_wave_speed_left  = ows_l_r;
  assign out_local_cfl        = ocfl_r;
  assign out_running_cfl      = max_r;
  assign out_saturated        = osat_r;

endmodule

// ----- rtl/core/hydro_wave_speed_cfl_top.sv -----
// Top level: configuration registers, sequencer and datapath of the wave speed block.
//
//   channel  | handshake            | payload
//   in_      | in_valid / in_stall  | densities, velocities, pressures, direction, restart
//   out_     | out_valid/ out_stall | wave speeds, local and running CFL, saturated
//   cfg_     | cfg_we               | cfg_index, cfg_wdata
//
// The block works on one item at a time: per side one multiply, 66 divider
// steps, one setup and 32 square root steps, then speed, CFL multiply and
// finish. A single bit-serial divide/root unit serves both sides.
// Reset is synchronous, active low; it clears the running maximum and loads
// the register defaults. A stalled result holds; the next item is accepted meanwhile.
module hydro_wave_speed_cfl_top import hwcfl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [DATA_W-1:0]        in_density_left,
  input  logic [DATA_W-1:0]        in_density_right,
  input  logic signed [DATA_W-1:0] in_velocity_left,
  input  logic signed [DATA_W-1:0] in_velocity_right,
  input  logic [DATA_W-1:0]        in_pressure_left,
  input  logic [DATA_W-1:0]        in_pressure_right,
  input  logic [DIR_W-1:0]         in_direction,
  input  logic                     in_restart_max,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DATA_W-1:0]        out_wave_speed_right,
  output logic [DATA_W-1:0]        out_wave_speed_left,
  output logic [DATA_W-1:0]        out_local_cfl,
  output logic [DATA_W-1:0]        out_running_cfl,
  output logic                     out_saturated
);

  logic [GAMMA_W-1:0] gamma_r;
  logic [DATA_W-1:0]  inv_x_r, inv_y_r, inv_z_r;
  cmd_t               cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RESET;
      inv_x_r <= INV_RESET;
      inv_y_r <= INV_RESET;
      inv_z_r <= INV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAMMA: gamma_r <= cfg_wdata[GAMMA_W-1:0];
        CFG_INV_X: inv_x_r <= cfg_wdata;
        CFG_INV_Y: inv_y_r <= cfg_wdata;
        CFG_INV_Z: inv_z_r <= cfg_wdata;
        default:   gamma_r <= gamma_r;
      endcase
    end
  end

  hwcfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  hwcfl_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .gamma                (gamma_r),
    .inv_x                (inv_x_r),
    .inv_y                (inv_y_r),
    .inv_z                (inv_z_r),
    .in_density_left      (in_density_left),
    .in_density_right     (in_density_right),
    .in_velocity_left     (in_velocity_left),
    .in_velocity_right    (in_velocity_right),
    .in_pressure_left     (in_pressure_left),
    .in_pressure_right    (in_pressure_right),
    .in_direction         (in_direction),
    .in_restart_max       (in_restart_max),
    .out_wave_speed_right (out_wave_speed_right),
    .out_wave_speed_left  (out_wave_speed_left),
    .out_local_cfl        (out_local_cfl),
    .out_running_cfl      (out_running_cfl),
    .out_saturated        (out_saturated)
  );

endmodule

// ----- tb/sv/tb_hydro_wave_speed_cfl_checker.sv -----
// Checker for the wave speed block: predicts each result and compares it on the out_ channel.
`timescale 1ns / 1ps

module tb_hydro_wave_speed_cfl_checker import hwcfl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [DATA_W-1:0]        in_density_left,
  input  logic [DATA_W-1:0]        in_density_right,
  input  logic signed [DATA_W-1:0] in_velocity_left,
  input  logic signed [DATA_W-1:0] in_velocity_right,
  input  logic [DATA_W-1:0]        in_pressure_left,
  input  logic [DATA_W-1:0]        in_pressure_right,
  input  logic [DIR_W-1:0]         in_direction,
  input  logic                     in_restart_max,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [DATA_W-1:0]        out_wave_speed_right,
  input  logic [DATA_W-1:0]        out_wave_speed_left,
  input  logic [DATA_W-1:0]        out_local_cfl,
  input  logic [DATA_W-1:0]        out_running_cfl,
  input  logic                     out_saturated,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic [DATA_W-1:0] speed_right;
    logic [DATA_W-1:0] speed_left;
    logic [DATA_W-1:0] local_cfl;
    logic [DATA_W-1:0] running_cfl;
    logic              saturated;
  } speed_result_t;

  localparam longint SPEED_MAX = 64'hFFFF_FFFF;

  logic [GAMMA_W-1:0] gamma_q;
  logic [DATA_W-1:0]  inv_x, inv_y, inv_z;
  logic [DATA_W-1:0]  cfl_peak;
  speed_result_t      expected_speeds[$];

  // Sound speed in Q16.16; bit 32 flags a clipped square.
  function automatic logic [DATA_W:0] sound_speed(logic [DATA_W-1:0] rho,
                                                  logic [DATA_W-1:0] p);
    logic [47:0] num;
    logic [65:0] sq_w;
    logic [63:0] sq;
    logic [31:0] root;
    logic [31:0] trial;
    logic        clip;
    num  = 48'(gamma_q) * 48'(p);
    clip = 1'b0;
    if (rho == '0) rho = 1;
    sq_w = {num, 18'b0} / 66'(rho);
    if (sq_w[65:64] != 2'b00) begin
      sq   = '1;
      clip = 1'b1;
    end else begin
      sq = sq_w[63:0];
    end
    // Build the truncated root one bit at a time.
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (64'(trial) * 64'(trial) <= sq) root = trial;
    end
    return {clip, root};
  endfunction

  // Largest of two signed speeds, floored at zero and clipped to the result maximum.
  function automatic logic [DATA_W:0] clip_speed(longint a, longint b);
    longint m;
    m = (a > b) ? a : b;
    if (m < 0) m = 0;
    if (m > SPEED_MAX) return {1'b1, 32'hFFFF_FFFF};
    return {1'b0, m[31:0]};
  endfunction

  function automatic speed_result_t predict_speeds();
    speed_result_t r;
    logic [DATA_W:0] cs_l, cs_r, vr, vl;
    logic [DATA_W-1:0] vmax, inv;
    logic [63:0] prod;
    logic [47:0] cfl_w;
    longint ul, ur;
    if (in_restart_max) cfl_peak = '0;
    cs_l = sound_speed(in_density_left, in_pressure_left);
    cs_r = sound_speed(in_density_right, in_pressure_right);
    ul = longint'(in_velocity_left);
    ur = longint'(in_velocity_right);
    vr = clip_speed(longint'(cs_l[31:0]) + ul, longint'(cs_r[31:0]) + ur);
    vl = clip_speed(longint'(cs_l[31:0]) - ul, longint'(cs_r[31:0]) - ur);
    vmax = (vr[31:0] > vl[31:0]) ? vr[31:0] : vl[31:0];
    inv = (in_direction == DIR_X) ? inv_x : (in_direction == DIR_Y) ? inv_y : inv_z;
    prod = 64'(vmax) * 64'(inv);
    cfl_w = prod[63:16];
    r.saturated = cs_l[32] | cs_r[32] | vr[32] | vl[32];
    if (cfl_w[47:32] != '0) begin
      r.local_cfl = '1;
      r.saturated = 1'b1;
    end else begin
      r.local_cfl = cfl_w[31:0];
    end
    if (r.local_cfl > cfl_peak) cfl_peak = r.local_cfl;
    r.speed_right = vr[31:0];
    r.speed_left  = vl[31:0];
    r.running_cfl = cfl_peak;
    return r;
  endfunction

  assign pending = expected_speeds.size();

  // Track registers, predict accepted items and compare accepted results.
  always @(posedge clk) begin
    speed_result_t e;
    if (!rst_n) begin
      gamma_q  <= GAMMA_RESET;
      inv_x    <= INV_RESET;
      inv_y    <= INV_RESET;
      inv_z    <= INV_RESET;
      cfl_peak  = '0;
      expected_speeds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAMMA: gamma_q <= cfg_wdata[GAMMA_W-1:0];
          CFG_INV_X: inv_x <= cfg_wdata;
          CFG_INV_Y: inv_y <= cfg_wdata;
          CFG_INV_Z: inv_z <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_speeds.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          e = expected_speeds.pop_front();
          if (out_wave_speed_right !== e.speed_right) begin
            $error("wave_speed_right exp %h got %h", e.speed_right, out_wave_speed_right);
            fail_count++;
          end
          if (out_wave_speed_left !== e.speed_left) begin
            $error("wave_speed_left exp %h got %h", e.speed_left, out_wave_speed_left);
            fail_count++;
          end
          if (out_local_cfl !== e.local_cfl) begin
            $error("local_cfl exp %h got %h", e.local_cfl, out_local_cfl);
            fail_count++;
          end
          if (out_running_cfl !== e.running_cfl) begin
            $error("running_cfl exp %h got %h", e.running_cfl, out_running_cfl);
            fail_count++;
          end
          if (out_saturated !== e.saturated) begin
            $error("saturated exp %b got %b", e.saturated, out_saturated);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) expected_speeds.push_back(predict_speeds());
    end
  end

  initial fail_count = 0;

endmodule

// ----- tb/sv/tb_hydro_wave_speed_cfl_top.sv -----
// Testbench top: clock, reset, register writes, item stimulus and verdict.
`timescale 1ns / 1ps

module tb_hydro_wave_speed_cfl_top;
  import hwcfl_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 250;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic [DATA_W-1:0]        in_density_left, in_density_right;
  logic signed [DATA_W-1:0] in_velocity_left, in_velocity_right;
  logic [DATA_W-1:0]        in_pressure_left, in_pressure_right;
  logic [DIR_W-1:0]         in_direction;
  logic                     in_restart_max;
  logic                     out_valid;
  logic                     out_stall;
  logic [DATA_W-1:0]        out_wave_speed_right, out_wave_speed_left;
  logic [DATA_W-1:0]        out_local_cfl, out_running_cfl;
  logic                     out_saturated;
  int                       fail_count;
  int                       pending;
  bit                       calm;
  bit                       hold_req;
  int                       idle_cycles;

  hydro_wave_speed_cfl_top dut (.*);
  tb_hydro_wave_speed_cfl_checker checker_i (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, a long hold-off on request, none while calm.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (800) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 18);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every expected result has come, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(logic [31:0] rl, logic [31:0] rr, logic [31:0] ul,
                           logic [31:0] ur, logic [31:0] pl, logic [31:0] pr,
                           logic [1:0] dir, logic rst_max);
    in_valid          <= 1'b1;
    in_density_left   <= rl;
    in_density_right  <= rr;
    in_velocity_left  <= ul;
    in_velocity_right <= ur;
    in_pressure_left  <= pl;
    in_pressure_right <= pr;
    in_direction      <= dir;
    in_restart_max    <= rst_max;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Drop valid now and then for a short gap.
    if (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Random value spread over magnitudes so every bit toggles.
  function automatic logic [31:0] spread();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(3) != 0) v = v >> $urandom_range(31);
    return v;
  endfunction

  function automatic logic [31:0] rand_velocity();
    logic [31:0] v;
    v = spread();
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic random_items(int count);
    logic [31:0] rl, rr;
    for (int i = 0; i < count; i++) begin
      rl = spread();
      rr = spread();
      if (rl == '0) rl = 32'd1;
      if (rr == '0) rr = 32'd1;
      send_item(rl, rr, rand_velocity(), rand_velocity(), spread(), spread(),
                2'($urandom_range(2)), $urandom_range(9) == 0);
    end
  endtask

  initial begin
    logic [31:0] one;
    one       = 32'h0001_0000;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_GAMMA;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_density_left  = one;
    in_density_right = one;
    in_velocity_left = '0;
    in_velocity_right = '0;
    in_pressure_left = '0;
    in_pressure_right = '0;
    in_direction     = DIR_X;
    in_restart_max   = 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every axis, restart, zero density, direction three.
    send_item(one, one, '0, '0, '0, '0, DIR_X, 1'b0);
    send_item(one, one, one, -one, one, one, DIR_Y, 1'b0);
    send_item(32'd1, 32'd1, '0, '0, '1, '1, 2'd2, 1'b0);
    send_item('1, '1, '0, '0, 32'd1, 32'd1, DIR_X, 1'b0);
    send_item('1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, DIR_Y, 1'b0);
    send_item('1, '1, 32'h8000_0000, 32'h8000_0000, '1, '1, 2'd2, 1'b0);
    send_item(32'd1, one, 32'h7FFF_FFFF, 32'h8000_0000, '1, '0, DIR_X, 1'b1);
    send_item('0, '0, 32'd5, -32'd5, one, one, DIR_X, 1'b0);
    send_item(one, 32'h0002_0000, -one, one, one, one, 2'd3, 1'b0);
    send_item(one, one, '0, '0, one, one, DIR_Y, 1'b1);
    send_item(one, one, -32'h0100_0000, -32'h0100_0000, '0, '0, 2'd2, 1'b0);
    send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
              32'hAAAA_AAAA, 32'h5555_5555, DIR_X, 1'b0);
    drain();

    // Extreme registers: largest gamma and spacings.
    write_reg(CFG_GAMMA, 32'h0000_FFFF);
    write_reg(CFG_INV_X, '1);
    write_reg(CFG_INV_Y, '1);
    write_reg(CFG_INV_Z, '1);
    send_item(32'd1, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1, 2'd2, 1'b1);
    send_item(one, one, one, one, one, one, DIR_X, 1'b0);
    random_items(150);
    drain();

    // Zero gamma and zero spacings.
    write_reg(CFG_GAMMA, '0);
    write_reg(CFG_INV_X, '0);
    write_reg(CFG_INV_Y, '0);
    write_reg(CFG_INV_Z, '0);
    random_items(60);
    drain();

    // Random registers; long stall that holds a result and stops the sender behind it.
    write_reg(CFG_GAMMA, $urandom_range(65535));
    write_reg(CFG_INV_X, spread());
    write_reg(CFG_INV_Y, spread());
    write_reg(CFG_INV_Z, spread());
    hold_req = 1'b1;
    random_items(200);
    drain();

    // Typical values with a stretch free of any gaps.
    write_reg(CFG_GAMMA, 32'd27307);
    write_reg(CFG_INV_X, 32'h0010_0000);
    write_reg(CFG_INV_Y, 32'h0000_8000);
    write_reg(CFG_INV_Z, 32'h0100_0000);
    calm = 1'b1;
    random_items(120);
    calm = 1'b0;
    random_items(180);
    drain();

    write_reg(CFG_GAMMA, $urandom_range(65535));
    write_reg(CFG_INV_X, $urandom);
    write_reg(CFG_INV_Y, $urandom);
    write_reg(CFG_INV_Z, $urandom);
    random_items(130);
    drain();

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
